// File: rtl/core/fat_pkg.sv
// ============================================================================
// fat_pkg: frame animation timer shared definitions
// Item kind codes, field widths and parameter defaults.
// ============================================================================
package fat_pkg;

    localparam int KIND_W  = 2;
    localparam int ELAP_W  = 16;
    localparam int COUNT_W = 5;
    localparam int IDX_W   = 4;
    localparam int DUR_W   = 16;
    localparam int FRAME_W = 4;
    localparam int ACC_W   = 32;
    localparam int FRAC_W  = 4;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int MAX_STEPS_DEF  = 256;

    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd3;

endpackage

// File: rtl/core/frame_animation_timer.sv
// ============================================================================
// frame_animation_timer: sprite frame animation timer
// Per-frame duration table, clip playback with loop or stop-at-end, driven
// by tick items carrying elapsed time in Q4 milliseconds.
// ============================================================================
// An item is taken when start is high and busy is low; busy then stays high
// until the result has been shown on done for one cycle, and the receiver
// cannot stall it. Play, stop, load and an idle tick go straight to the
// result. A tick on a running clip advances at most MAX_STEPS frames, halting
// on the last frame of a non-looping clip: one 33-bit add/subtract unit first
// adds the elapsed time with saturation, then for each frame compares and
// subtracts the duration, and each new frame passes through a fetch state for
// the registered table read.
module frame_animation_timer #(
    parameter int MAX_FRAMES = fat_pkg::MAX_FRAMES_DEF,
    parameter int MAX_STEPS  = fat_pkg::MAX_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fat_pkg::KIND_W-1:0]    kind,
    input  logic [fat_pkg::ELAP_W-1:0]    elapsed_q4,
    input  logic                          loop_mode,
    input  logic [fat_pkg::COUNT_W-1:0]   frame_count_in,
    input  logic [fat_pkg::IDX_W-1:0]     frame_index,
    input  logic [fat_pkg::DUR_W-1:0]     frame_duration_ms,
    output logic                          done,
    output logic [fat_pkg::FRAME_W-1:0]   current_frame,
    output logic                          playing,
    output logic                          finished
);
    import fat_pkg::*;

    localparam int CNT_MAX = (1 << COUNT_W) - 1;
    localparam int LEN_MAX = (MAX_FRAMES < CNT_MAX) ? MAX_FRAMES : CNT_MAX;
    localparam int LEN_W   = $clog2(LEN_MAX + 1);
    localparam int FR_W    = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;
    localparam int TAB_D   = (MAX_FRAMES < (1 << IDX_W)) ? MAX_FRAMES : (1 << IDX_W);
    localparam int TAB_AW  = (TAB_D > 1) ? $clog2(TAB_D) : 1;
    localparam int STEP_W  = $clog2(MAX_STEPS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]        state_reg,   state_next;
    logic [ACC_W-1:0]  acc_reg,     acc_next;
    logic [FR_W-1:0]   frame_reg,   frame_next;
    logic [LEN_W-1:0]  len_reg,     len_next;
    logic              running_reg, running_next;
    logic              looping_reg, looping_next;
    logic              present_reg, present_next;
    logic [STEP_W-1:0] steps_reg,   steps_next;
    logic [ELAP_W-1:0] elap_reg;

    logic [DUR_W-1:0]  tab [TAB_D];
    logic [DUR_W-1:0]  rd_reg;
    logic              rd_ok_reg;

    logic              accept;
    logic              tab_we;
    logic [IDX_W+TAB_AW-1:0] widx;
    logic [ACC_W-1:0]  need;
    logic [ACC_W-1:0]  alu_b;
    logic              alu_cin;
    logic [ACC_W:0]    alu_sum;
    logic [LEN_W-1:0]  frame_inc;
    logic [FR_W-1:0]   last_frame;
    logic [LEN_W-1:0]  count_sat;
    logic [FR_W+FRAME_W-1:0] frame_ext;

    assign accept    = start && (state_reg == S_IDLE);
    assign tab_we    = accept && (kind == KIND_LOAD) && (frame_index < TAB_D);
    assign widx      = {{TAB_AW{1'b0}}, frame_index};
    assign need      = rd_ok_reg ? {{(ACC_W-DUR_W-FRAC_W){1'b0}}, rd_reg, {FRAC_W{1'b0}}}
                                 : '0;
    assign alu_b     = (state_reg == S_ADD) ? {{(ACC_W-ELAP_W){1'b0}}, elap_reg} : ~need;
    assign alu_cin   = (state_reg != S_ADD);
    assign alu_sum   = {1'b0, acc_reg} + {1'b0, alu_b} + {{ACC_W{1'b0}}, alu_cin};
    assign frame_inc = LEN_W'(frame_reg) + LEN_W'(1);
    assign last_frame = FR_W'(len_reg - LEN_W'(1));
    assign count_sat = (frame_count_in > COUNT_W'(LEN_MAX)) ? LEN_W'(LEN_MAX)
                                                            : LEN_W'(frame_count_in);
    assign frame_ext = {{FRAME_W{1'b0}}, frame_reg};

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab[widx[TAB_AW-1:0]] <= frame_duration_ms;
        end
        rd_reg    <= tab[frame_reg[TAB_AW-1:0]];
        rd_ok_reg <= (frame_reg < TAB_D);
        if (accept)
        begin
            elap_reg <= elapsed_q4;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        frame_next   = frame_reg;
        len_next     = len_reg;
        running_next = running_reg;
        looping_next = looping_reg;
        present_next = present_reg;
        steps_next   = steps_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DONE;
                    case (kind)
                        KIND_TICK:
                        begin
                            if (running_reg && present_reg)
                            begin
                                state_next = S_ADD;
                            end
                        end
                        KIND_PLAY:
                        begin
                            if (frame_count_in != '0)
                            begin
                                len_next     = count_sat;
                                present_next = 1'b1;
                                looping_next = loop_mode;
                                frame_next   = '0;
                                acc_next     = '0;
                                running_next = 1'b1;
                            end
                        end
                        KIND_STOP:
                        begin
                            running_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                acc_next   = alu_sum[ACC_W] ? {ACC_W{1'b1}} : alu_sum[ACC_W-1:0];
                steps_next = '0;
                state_next = S_STEP;
            end
            S_FETCH:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (alu_sum[ACC_W] && (steps_reg < STEP_W'(MAX_STEPS)))
                begin
                    acc_next   = alu_sum[ACC_W-1:0];
                    steps_next = steps_reg + STEP_W'(1);
                    state_next = S_FETCH;
                    if (frame_inc >= len_reg)
                    begin
                        if (looping_reg)
                        begin
                            frame_next = '0;
                        end
                        else
                        begin
                            frame_next   = last_frame;
                            running_next = 1'b0;
                            state_next   = S_DONE;
                        end
                    end
                    else
                    begin
                        frame_next = FR_W'(frame_inc);
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            acc_reg     <= '0;
            frame_reg   <= '0;
            len_reg     <= '0;
            running_reg <= 1'b0;
            looping_reg <= 1'b0;
            present_reg <= 1'b0;
            steps_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            frame_reg   <= frame_next;
            len_reg     <= len_next;
            running_reg <= running_next;
            looping_reg <= looping_next;
            present_reg <= present_next;
            steps_reg   <= steps_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_DONE);
    assign current_frame = frame_ext[FRAME_W-1:0];
    assign playing       = running_reg;
    assign finished      = !running_reg && !looping_reg && present_reg &&
                           (frame_reg == last_frame);

endmodule

// File: rtl/core/fat_chk.sv
// ============================================================================
// fat_chk: frame animation timer port checker
// Watches the command handshake and result strobe at the top-level ports.
// ============================================================================
module fat_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [fat_pkg::FRAME_W-1:0] current_frame,
    input logic                        playing,
    input logic                        finished
);
    import fat_pkg::*;

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item taken but busy did not rise");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while not busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_fin_stop: assert property (@(posedge clk) disable iff (!rst_n)
        done && finished |-> !playing)
        else $error("finished while playing");

    a_done_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({current_frame, playing, finished}))
        else $error("unknown result fields on done");

endmodule

bind frame_animation_timer fat_chk u_fat_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .current_frame (current_frame),
    .playing       (playing),
    .finished      (finished)
);

// File: verif/frame_animation_timer_test.sv
// ----------------------------------------------------------------------------
// frame_animation_timer_test: self-checking bench for the frame animation timer
// Walks a short table of directed items (reset state, extremes, zero and
// oversized clip lengths, single-frame finish, step cap on zero durations),
// then a long random mix of play, tick, stop and load items. Every accepted
// item is run through a local predictor; each done strobe is compared field by
// field to the oldest prediction, or to the row's view where chk is set.
// ----------------------------------------------------------------------------
module frame_animation_timer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fat_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 12;
    localparam int LIVE_ITEMS  = 1200;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int DRAIN_CYC   = 16;
    localparam int N_DIRECTED  = 24;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ELAP_W-1:0]  elapsed_q4;
        logic               loop_mode;
        logic [COUNT_W-1:0] frame_count_in;
        logic [IDX_W-1:0]   frame_index;
        logic [DUR_W-1:0]   frame_duration_ms;
    } anim_cmd_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               playing;
        logic               finished;
    } anim_view_t;

    typedef struct packed {
        anim_cmd_t  cmd;
        logic       chk;
        anim_view_t view;
    } anim_row_t;

    localparam anim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{KIND_TICK, 16'hFFFF, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_STOP, 16'h0000, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_PLAY, 16'h0000, 1'b1, 5'd0,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_LOAD, 16'h0000, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_LOAD, 16'h0000, 1'b0, 5'd0,  4'd1, 16'h0000}, 1'b1, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_LOAD, 16'h0000, 1'b0, 5'd0,  4'd2, 16'hFFFF}, 1'b1, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_LOAD, 16'h0000, 1'b0, 5'd0,  4'd3, 16'h0001}, 1'b1, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_PLAY, 16'h0000, 1'b0, 5'd1,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b1, 1'b0}},
        '{'{KIND_TICK, 16'h0000, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b0, 1'b1}},
        '{'{KIND_TICK, 16'hFFFF, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b0, 1'b1}},
        '{'{KIND_PLAY, 16'h0000, 1'b1, 5'd2,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b1, 1'b0}},
        '{'{KIND_TICK, 16'h0000, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b0, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_STOP, 16'h0000, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_PLAY, 16'h0000, 1'b0, 5'd3,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b1, 1'b0}},
        '{'{KIND_TICK, 16'h0000, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b0, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_TICK, 16'hFFFF, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b0, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_STOP, 16'h0000, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b0, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_PLAY, 16'h0000, 1'b0, 5'd4,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b1, 1'b0}},
        '{'{KIND_TICK, 16'h0000, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b0, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_TICK, 16'hFFFF, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b0, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_PLAY, 16'h0000, 1'b0, 5'd31, 4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b1, 1'b0}},
        '{'{KIND_STOP, 16'h0000, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b0, 1'b0}},
        '{'{KIND_PLAY, 16'h0000, 1'b1, 5'd16, 4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b1, 1'b0}},
        '{'{KIND_STOP, 16'h0000, 1'b0, 5'd0,  4'd0, 16'h0000}, 1'b1, '{4'd0, 1'b0, 1'b0}}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [KIND_W-1:0]   kind = KIND_TICK;
    logic [ELAP_W-1:0]   elapsed_q4 = '0;
    logic                loop_mode = 1'b0;
    logic [COUNT_W-1:0]  frame_count_in = '0;
    logic [IDX_W-1:0]    frame_index = '0;
    logic [DUR_W-1:0]    frame_duration_ms = '0;
    logic                done;
    logic [FRAME_W-1:0]  current_frame;
    logic                playing;
    logic                finished;

    // predictor state
    logic [DUR_W-1:0]          dur_tab [MAX_FRAMES_DEF];
    logic [MAX_FRAMES_DEF-1:0] dur_written = '0;
    logic [COUNT_W-1:0]        clip_len = '0;
    logic [FRAME_W-1:0]        frame_pos = '0;
    logic [ACC_W-1:0]          acc_q4 = '0;
    logic                      run_flag = 1'b0;
    logic                      loop_flag = 1'b0;
    logic                      clip_flag = 1'b0;

    anim_view_t view_expect_q [$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         no_gap_left = 0;

    frame_animation_timer uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .kind              (kind),
        .elapsed_q4        (elapsed_q4),
        .loop_mode         (loop_mode),
        .frame_count_in    (frame_count_in),
        .frame_index       (frame_index),
        .frame_duration_ms (frame_duration_ms),
        .done              (done),
        .current_frame     (current_frame),
        .playing           (playing),
        .finished          (finished)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic [ACC_W-1:0] frame_need_q4(input logic [FRAME_W-1:0] f);
        return {{(ACC_W-DUR_W-FRAC_W){1'b0}}, dur_tab[f], {FRAC_W{1'b0}}};
    endfunction

    function automatic anim_view_t step_animation(input anim_cmd_t c);
        anim_view_t        v;
        logic [ACC_W-1:0]  need;
        logic [COUNT_W-1:0] nxt;
        int                steps;
        case (c.kind)
            KIND_TICK:
            begin
                if (run_flag && clip_flag && clip_len != '0)
                begin
                    if (acc_q4 > ({ACC_W{1'b1}} - ACC_W'(c.elapsed_q4)))
                        acc_q4 = {ACC_W{1'b1}};
                    else
                        acc_q4 = acc_q4 + ACC_W'(c.elapsed_q4);
                    need = frame_need_q4(frame_pos);
                    steps = 0;
                    while (acc_q4 >= need && steps < MAX_STEPS_DEF)
                    begin
                        acc_q4 = acc_q4 - need;
                        steps++;
                        nxt = COUNT_W'(frame_pos) + 1'b1;
                        if (nxt >= clip_len)
                        begin
                            if (loop_flag)
                                nxt = '0;
                            else
                            begin
                                frame_pos = FRAME_W'(clip_len - 1'b1);
                                run_flag = 1'b0;
                                break;
                            end
                        end
                        frame_pos = FRAME_W'(nxt);
                        need = frame_need_q4(frame_pos);
                    end
                end
            end
            KIND_PLAY:
            begin
                if (c.frame_count_in != '0)
                begin
                    clip_len = (c.frame_count_in > COUNT_W'(MAX_FRAMES_DEF)) ?
                               COUNT_W'(MAX_FRAMES_DEF) : c.frame_count_in;
                    clip_flag = 1'b1;
                    loop_flag = c.loop_mode;
                    frame_pos = '0;
                    acc_q4 = '0;
                    run_flag = 1'b1;
                end
            end
            KIND_STOP:
                run_flag = 1'b0;
            default:
            begin
                dur_tab[c.frame_index] = c.frame_duration_ms;
                dur_written[c.frame_index] = 1'b1;
            end
        endcase
        v.frame = frame_pos;
        v.playing = run_flag;
        v.finished = !run_flag && !loop_flag && clip_flag && clip_len != '0 &&
                     COUNT_W'(frame_pos) == clip_len - 1'b1;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            no_gap_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic anim_cmd_t random_cmd();
        anim_cmd_t c;
        int        r;
        int        hole;
        c.kind              = KIND_W'($urandom);
        c.elapsed_q4        = ELAP_W'($urandom);
        c.loop_mode         = 1'($urandom);
        c.frame_count_in    = COUNT_W'($urandom);
        c.frame_index       = IDX_W'($urandom);
        c.frame_duration_ms = DUR_W'($urandom);
        r = $urandom_range(0, 99);
        if (!run_flag && r < 40)
            c.kind = KIND_PLAY;
        else if (r < 50)
            c.kind = KIND_TICK;
        else if (r < 65)
            c.kind = KIND_PLAY;
        else if (r < 73)
            c.kind = KIND_STOP;
        else
            c.kind = KIND_LOAD;
        r = $urandom_range(0, 99);
        case (c.kind)
            KIND_TICK:
            begin
                if (r < 25)
                    c.elapsed_q4 = ELAP_W'($urandom_range(0, 63));
                else if (r < 75)
                    c.elapsed_q4 = ELAP_W'($urandom_range(0, 1023));
            end
            KIND_PLAY:
            begin
                if (r < 75)
                    c.frame_count_in = COUNT_W'($urandom_range(1, MAX_FRAMES_DEF));
                else if (r < 88)
                    c.frame_count_in = COUNT_W'($urandom_range(MAX_FRAMES_DEF + 1, 31));
                else
                    c.frame_count_in = '0;
            end
            KIND_LOAD:
            begin
                if (r < 20)
                    c.frame_duration_ms = DUR_W'($urandom_range(0, 2));
                else if (r < 75)
                    c.frame_duration_ms = DUR_W'($urandom_range(1, 64));
            end
            default:
            begin
            end
        endcase
        // a running tick reads durations of the whole clip: fill any gap first
        if (c.kind == KIND_TICK && run_flag && clip_flag)
        begin
            hole = -1;
            for (int k = int'(clip_len) - 1; k >= 0; k--)
                if (!dur_written[k])
                    hole = k;
            if (hole >= 0)
            begin
                c.kind = KIND_LOAD;
                c.frame_index = IDX_W'(hole);
                c.frame_duration_ms = DUR_W'($urandom_range(0, 64));
            end
        end
        return c;
    endfunction

    task automatic issue_cmd(input anim_cmd_t c, input logic typed, input anim_view_t tv);
        anim_view_t pv;
        kind              <= c.kind;
        elapsed_q4        <= c.elapsed_q4;
        loop_mode         <= c.loop_mode;
        frame_count_in    <= c.frame_count_in;
        frame_index       <= c.frame_index;
        frame_duration_ms <= c.frame_duration_ms;
        start             <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pv = step_animation(c);
        view_expect_q.push_back(typed ? tv : pv);
    endtask

    initial
    begin
        int        gap;
        int        live;
        anim_cmd_t c;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            issue_cmd(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].chk, DIRECTED_ROWS[i].view);
        end
        live = 0;
        while (live < LIVE_ITEMS)
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            c = random_cmd();
            if (!(c.kind == KIND_PLAY && c.frame_count_in == '0) &&
                !(c.kind == KIND_TICK && !run_flag))
                live++;
            issue_cmd(c, 1'b0, '0);
        end
        start <= 1'b0;
        while (view_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        anim_view_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (view_expect_q.size() == 0)
            begin
                $error("result with no item pending: current_frame %0d", current_frame);
                mismatch_count++;
            end
            else
            begin
                want = view_expect_q.pop_front();
                if (current_frame !== want.frame)
                begin
                    $error("current_frame: expected %0d, got %0d", want.frame, current_frame);
                    mismatch_count++;
                end
                if (playing !== want.playing)
                begin
                    $error("playing: expected %0b, got %0b", want.playing, playing);
                    mismatch_count++;
                end
                if (finished !== want.finished)
                begin
                    $error("finished: expected %0b, got %0b", want.finished, finished);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
